// ----- sv/ufcd_pkg.sv -----
// Shared types and constants of the serial-to-packet deframer.
package ufcd_pkg;

	localparam int FrameLen    = 18;
	localparam int StoredLen   = FrameLen - 1;
	localparam int IdW         = 11;
	localparam int SumW        = 13;
	localparam int FillW       = 5;
	localparam int PayloadLen  = 8;
	localparam int PayloadBase = 9;

	typedef logic [7:0]       byte_t;
	typedef logic [IdW-1:0]   id_t;
	typedef logic [SumW-1:0]  sum_t;
	typedef logic [FillW-1:0] fill_t;

	// Stored window: entry 0 is the oldest byte, the newest byte is not stored yet.
	typedef byte_t [StoredLen-1:0] window_t;

	localparam byte_t StartByte   = 8'hF0;
	localparam byte_t TypeByte    = 8'h55;
	localparam byte_t ChannelByte = 8'hAA;

	localparam fill_t FillFull = fill_t'(StoredLen);

	typedef enum logic [1:0] {
		CfgMsgIdLow    = 2'd0,
		CfgMsgIdHigh   = 2'd1,
		CfgStatusId    = 2'd2,
		CfgHeartbeatId = 2'd3
	} cfg_idx_t;

	localparam id_t MsgIdLowRst    = 11'd1024;
	localparam id_t MsgIdHighRst   = 11'd1031;
	localparam id_t StatusIdRst    = 11'd1664;
	localparam id_t HeartbeatIdRst = 11'd1672;

	typedef struct packed {
		id_t msg_id_low;
		id_t msg_id_high;
		id_t status_id;
		id_t heartbeat_id;
	} cfg_t;

	typedef struct packed {
		id_t                          can_id;
		byte_t [PayloadLen-1:0]       data;
	} result_t;

	typedef struct packed {
		logic    pass;
		logic    hit;
		result_t res;
	} decision_t;

endpackage

// ----- sv/usb_frame_to_can_deframer.sv -----
// Top level of the serial-to-packet deframer: byte window, frame check and output stage.
//
// The block takes one received byte per item and accepts a byte in every clock
// cycle while the skid entry is free. Bytes shift through a row of 17 cells; each
// cell also carries the sum of its own byte and all newer ones, so the checksum of
// the oldest 17 bytes is ready in a register when the 18th byte arrives, and the
// start byte, checksum, type, channel and id filter are decided in the same cycle
// that byte is accepted. A frame that passes empties the window; one that fails
// drops its oldest byte, so the next byte completes a new candidate. A qualifying
// frame produces one item with the id and frame bytes 9 to 16, shown on the
// output in the cycle after its last byte was accepted when the result register
// is free, or is being taken with the skid entry empty; otherwise it waits in
// the skid entry until the items ahead of it are taken. The output has a result
// register and one skid entry: the input stalls only while both hold items that
// have not been taken. There is no clearing pass after reset; reset clears the
// fill count, configuration and output valid flags. Configuration writes take
// effect at the next clock edge and should be made while no frame is in progress.
module usb_frame_to_can_deframer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  ufcd_pkg::byte_t        rx_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output ufcd_pkg::id_t          can_id,
	output ufcd_pkg::byte_t        data0,
	output ufcd_pkg::byte_t        data1,
	output ufcd_pkg::byte_t        data2,
	output ufcd_pkg::byte_t        data3,
	output ufcd_pkg::byte_t        data4,
	output ufcd_pkg::byte_t        data5,
	output ufcd_pkg::byte_t        data6,
	output ufcd_pkg::byte_t        data7,
	input  logic                   cfg_we,
	input  ufcd_pkg::cfg_idx_t     cfg_index,
	input  ufcd_pkg::id_t          cfg_data
);
	import ufcd_pkg::*;

	logic      accept;
	logic      q_full;
	cfg_t      cfg_q;
	fill_t     fill_q;
	fill_t     fill_d;
	window_t   win;
	sum_t      acc [StoredLen];
	decision_t dec;
	logic      emit;
	result_t   out_res;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Configuration registers, written directly by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.msg_id_low   <= MsgIdLowRst;
			cfg_q.msg_id_high  <= MsgIdHighRst;
			cfg_q.status_id    <= StatusIdRst;
			cfg_q.heartbeat_id <= HeartbeatIdRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgMsgIdLow:    cfg_q.msg_id_low   <= cfg_data;
				CfgMsgIdHigh:   cfg_q.msg_id_high  <= cfg_data;
				CfgStatusId:    cfg_q.status_id    <= cfg_data;
				CfgHeartbeatId: cfg_q.heartbeat_id <= cfg_data;
				default: ;
			endcase
		end
	end

	// Row of cells. The newest stored byte sits in the last cell, which starts a
	// fresh sum; every other cell takes its neighbor's byte and sum.
	for (genvar k = 0; k < StoredLen; k++) begin : g_cell
		if (k == StoredLen - 1) begin : g_tail
			ufcd_cell u_cell (
				.clk      (clk),
				.shift_en (accept),
				.byte_in  (rx_byte),
				.acc_in   ('0),
				.new_byte (rx_byte),
				.byte_q   (win[k]),
				.acc_q    (acc[k])
			);
		end else begin : g_body
			ufcd_cell u_cell (
				.clk      (clk),
				.shift_en (accept),
				.byte_in  (win[k+1]),
				.acc_in   (acc[k+1]),
				.new_byte (rx_byte),
				.byte_q   (win[k]),
				.acc_q    (acc[k])
			);
		end
	end

	// The stored cells are frame bytes 0 to 16; the arriving byte is byte 17.
	ufcd_check u_check (
		.win       (win),
		.acc0      (acc[0]),
		.last_byte (rx_byte),
		.cfg       (cfg_q),
		.dec       (dec)
	);

	// The window counts how many stored cells belong to the current candidate.
	// Once 17 are held, each new byte completes a frame: a good frame empties
	// the window and a bad one keeps the count at 17 as the row slides on.
	always_comb begin
		fill_d = fill_q;
		if (accept) begin
			if (fill_q == FillFull) begin
				fill_d = dec.pass ? '0 : FillFull;
			end else begin
				fill_d = fill_q + fill_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_d;
		end
	end

	assign emit = accept && (fill_q == FillFull) && dec.pass && dec.hit;

	ufcd_out_q u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (dec.res),
		.full      (q_full),
		.out_valid (out_valid),
		.out_data  (out_res),
		.out_ready (out_ready)
	);

	assign can_id = out_res.can_id;
	assign data0  = out_res.data[0];
	assign data1  = out_res.data[1];
	assign data2  = out_res.data[2];
	assign data3  = out_res.data[3];
	assign data4  = out_res.data[4];
	assign data5  = out_res.data[5];
	assign data6  = out_res.data[6];
	assign data7  = out_res.data[7];

	// The fill count never passes the number of stored cells.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FillFull)
		else $error("window fill count out of range");

	// A good frame leaves an empty window behind.
	a_pass_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (fill_q == FillFull) && dec.pass) |=> (fill_q == '0))
		else $error("window not emptied after a good frame");

	// A bad frame keeps 17 bytes for the next candidate.
	a_fail_slides: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (fill_q == FillFull) && !dec.pass) |=> (fill_q == FillFull))
		else $error("window lost bytes after a bad frame");

	// Input stalls only while the result register is occupied.
	a_stall_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with an empty output register");

	// A packet that meets a stalled full output register goes into the skid entry.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && out_valid && !out_ready) |=> !in_ready)
		else $error("packet not held in the skid entry");

endmodule

// ----- sv/ufcd_cell.sv -----
// One window cell: holds a byte and the sum of that byte and all newer stored bytes.
module ufcd_cell (
	input  logic           clk,
	input  logic           shift_en,
	input  ufcd_pkg::byte_t byte_in,
	input  ufcd_pkg::sum_t  acc_in,
	input  ufcd_pkg::byte_t new_byte,
	output ufcd_pkg::byte_t byte_q,
	output ufcd_pkg::sum_t  acc_q
);
	import ufcd_pkg::*;

	// The running sum moves one cell toward the old end together with its byte,
	// and each arriving byte is added to every cell's sum on the way.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
			acc_q  <= acc_in + sum_t'(new_byte);
		end
	end

endmodule

// ----- sv/ufcd_check.sv -----
// Frame check and packet filter for a completed 18-byte window.
module ufcd_check (
	input  ufcd_pkg::window_t   win,
	input  ufcd_pkg::sum_t      acc0,
	input  ufcd_pkg::byte_t     last_byte,
	input  ufcd_pkg::cfg_t      cfg,
	output ufcd_pkg::decision_t dec
);
	import ufcd_pkg::*;

	logic [8:0] fold1;
	byte_t      fold2;
	byte_t      chk;
	id_t        id;
	logic       type_ok;
	logic       in_range;

	// Fold the sum twice into 8 bits, then take the two's complement.
	// The second fold cannot carry: a carry out of the first fold leaves at most 15
	// in the low byte.
	always_comb begin
		fold1 = 9'(acc0[7:0]) + 9'(acc0[SumW-1:8]);
		fold2 = fold1[7:0] + 8'(fold1[8]);
		chk   = ~fold2 + 8'd1;
	end

	assign id       = {win[4], win[5][7:5]};
	assign type_ok  = (win[1] == TypeByte) && (win[2] == ChannelByte);
	assign in_range = (id >= cfg.msg_id_low) && (id <= cfg.msg_id_high);

	always_comb begin
		dec.pass       = (win[0] == StartByte) && (chk == last_byte);
		dec.hit        = type_ok &&
		                 (in_range || (id == cfg.status_id) || (id == cfg.heartbeat_id));
		dec.res.can_id = id;
		for (int i = 0; i < PayloadLen; i++) begin
			dec.res.data[i] = win[PayloadBase + i];
		end
	end

endmodule

// ----- sv/ufcd_out_q.sv -----
// Two-entry output stage: a result register with one skid entry behind it.
module ufcd_out_q (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ufcd_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	output ufcd_pkg::result_t out_data,
	input  logic              out_ready
);
	import ufcd_pkg::*;

	logic    head_v_q;
	logic    skid_v_q;
	result_t head_q;
	result_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!head_v_q || out_ready) begin
			if (skid_v_q) begin
				head_v_q <= 1'b1;
				skid_v_q <= push;
			end else begin
				head_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!head_v_q || out_ready) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = head_v_q;
	assign out_data  = head_q;

endmodule
